### sv/sorted_list_insert_delete_unit_defines.svh
// Assertion macros for the sorted list insert and delete unit.
// Taken in by the checker module; depends on nothing else.
`ifndef SORTED_LIST_INSERT_DELETE_UNIT_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define SLI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted list unit: same-cycle check failed");

// Next-cycle implication that is also checked during reset.
`define SLI_ASSERT_NEXT_NORST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sorted list unit: next-cycle check failed");

`endif

### sv/sli_pkg.sv
// Shared types and constants of the sorted list insert and delete unit.
// Used by the top level, sli_front, sli_back and sli_checker; depends on nothing.
package sli_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned COUNT_OUT_W = 6;
  localparam int unsigned STATUS_W    = 2;

  // Command queue between the front and the back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EVAL,
    B_WRV
  } back_state_e;

  typedef struct packed {
    logic                      mode;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_e                   status;
    logic [COUNT_OUT_W-1:0]    entry_count;
    logic                      head_valid;
    logic signed [VALUE_W-1:0] head_value;
  } result_t;

  typedef struct packed {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
  } queue_item_t;

endpackage

### sv/sorted_list_insert_delete_unit.sv
// Top level of the sorted list insert and delete unit.
// Depends on sli_pkg, sli_front, sli_back and sli_ram.
//
// The unit keeps up to LIST_DEPTH signed 32-bit entries in ascending order.
// A command transaction is taken on a rising edge where start is high and busy
// is low; cmd_i.mode selects insert (0) or delete of the first equal entry (1).
// Each command yields exactly one result transaction: done_o is high for one
// cycle while result_o carries the status, the entry count after the command
// and the smallest entry held (zero when the list is empty).
// Commands go into a two-entry queue; busy is high only while it is full, so
// a new command can be taken while an earlier one is still being executed.
// The back end walks the entry RAM one entry at a time, with a read state and
// an evaluate state per entry, since its single read port has a registered
// output. An insert walks down from the top entry to its position; a delete
// walks every entry whether or not the value is found. A refused insert, an
// insert into an empty list and a delete on an empty list finish without a
// walk. A command that waits in the queue adds the time the back end still
// needs for the commands ahead of it.
// Sustained throughput is set by that walk, one command at a time.
// Reset clears the queue, the entry count and the state machine; the RAM
// itself is not cleared, since only entries below the count are ever read.
// The receiver cannot stall: every result is shown for exactly one cycle.
module sorted_list_insert_delete_unit #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  sli_pkg::cmd_t    cmd_i,
  output logic             busy,
  output logic             done_o,
  output sli_pkg::result_t result_o
);

  localparam int unsigned AW = $clog2(LIST_DEPTH);

  logic                          q_valid;
  logic                          q_pop;
  sli_pkg::queue_item_t          q_item;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [AW-1:0]                 ram_raddr;
  logic [sli_pkg::VALUE_W-1:0]   ram_wdata;
  logic [sli_pkg::VALUE_W-1:0]   ram_rdata;

  // Accepts commands and turns the mode bit into an operation code.
  sli_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (cmd_i),
    .busy_o  (busy),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  // Executes one queued command at a time against the entry RAM.
  sli_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (q_pop),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  // Entry store, kept in ascending order from address zero upward.
  sli_ram #(
    .WIDTH (sli_pkg::VALUE_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

### sv/sli_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the entry store of the sorted list unit.
module sli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/sli_front.sv
// Front part of the sorted list unit: accepts commands, classifies them and
// holds them in a two-entry queue for the back part. Depends on sli_pkg.
module sli_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  sli_pkg::cmd_t       cmd_i,
  output logic                busy_o,
  output logic                valid_o,
  output sli_pkg::queue_item_t item_o,
  input  logic                pop_i
);

  sli_pkg::queue_item_t               entries_q [sli_pkg::Q_DEPTH];
  sli_pkg::queue_item_t               item_in;
  logic [sli_pkg::Q_PTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [sli_pkg::Q_PTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [sli_pkg::Q_CNT_W-1:0]        count_q, count_d;
  logic                               full;
  logic                               push;

  assign full   = (count_q == sli_pkg::Q_CNT_W'(sli_pkg::Q_DEPTH));
  assign push   = start_i && !full;
  assign busy_o = full;
  assign valid_o = (count_q != '0);
  assign item_o  = entries_q[rd_ptr_q];

  // The mode bit becomes an operation code for the back part.
  always_comb begin
    item_in.value = cmd_i.value;
    if (cmd_i.mode) begin
      item_in.op = sli_pkg::OP_DELETE;
    end else begin
      item_in.op = sli_pkg::OP_INSERT;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

### sv/sli_back.sv
// Back part of the sorted list unit: walks the entry RAM to insert or delete
// one value per transaction and forms the result. Depends on sli_pkg.
module sli_back #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  sli_pkg::queue_item_t              item_i,
  output logic                              pop_o,
  output logic                              ram_we_o,
  output logic [$clog2(LIST_DEPTH)-1:0]     ram_waddr_o,
  output logic [sli_pkg::VALUE_W-1:0]       ram_wdata_o,
  output logic [$clog2(LIST_DEPTH)-1:0]     ram_raddr_o,
  input  logic [sli_pkg::VALUE_W-1:0]       ram_rdata_i,
  output logic                              done_o,
  output sli_pkg::result_t                  result_o
);

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  sli_pkg::back_state_e              state_q, state_d;
  logic [AW-1:0]                     k_q, k_d;
  logic [CW-1:0]                     count_q, count_d;
  sli_pkg::op_e                      op_q, op_d;
  logic signed [sli_pkg::VALUE_W-1:0] val_q, val_d;
  logic                              shift_q, shift_d;
  logic signed [sli_pkg::VALUE_W-1:0] head_q, head_d;
  logic                              done_q;
  sli_pkg::result_t                  res_q, res_d;

  logic                              finish;
  sli_pkg::status_e                  status;
  logic                              we;
  logic [AW-1:0]                     waddr;
  logic signed [sli_pkg::VALUE_W-1:0] wdata;
  logic signed [sli_pkg::VALUE_W-1:0] rdata;

  logic is_full, is_empty, is_last, k_zero, rd_ge, rd_eq, immediate;

  assign rdata    = $signed(ram_rdata_i);
  assign is_full  = (count_q == CW'(LIST_DEPTH));
  assign is_empty = (count_q == '0);
  assign is_last  = (CW'(k_q) == (count_q - CW'(1)));
  assign k_zero   = (k_q == '0);
  assign rd_ge    = (rdata >= val_q);
  assign rd_eq    = (rdata == val_q);
  assign immediate = (item_i.op == sli_pkg::OP_INSERT) ? (is_full || is_empty) : is_empty;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sli_pkg::B_IDLE: begin
        if (valid_i && !immediate) begin
          state_d = sli_pkg::B_READ;
        end
      end
      sli_pkg::B_READ: begin
        state_d = sli_pkg::B_EVAL;
      end
      sli_pkg::B_EVAL: begin
        if (op_q == sli_pkg::OP_INSERT) begin
          if (!rd_ge) begin
            state_d = sli_pkg::B_IDLE;
          end else if (k_zero) begin
            state_d = sli_pkg::B_WRV;
          end else begin
            state_d = sli_pkg::B_READ;
          end
        end else if (is_last) begin
          state_d = sli_pkg::B_IDLE;
        end else begin
          state_d = sli_pkg::B_READ;
        end
      end
      sli_pkg::B_WRV: begin
        state_d = sli_pkg::B_IDLE;
      end
      default: begin
        state_d = sli_pkg::B_IDLE;
      end
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    pop_o   = 1'b0;
    we      = 1'b0;
    waddr   = k_q;
    wdata   = val_q;
    k_d     = k_q;
    op_d    = op_q;
    val_d   = val_q;
    shift_d = shift_q;
    count_d = count_q;
    finish  = 1'b0;
    status  = sli_pkg::ST_DONE;
    case (state_q)
      sli_pkg::B_IDLE: begin
        if (valid_i) begin
          pop_o   = 1'b1;
          op_d    = item_i.op;
          val_d   = item_i.value;
          shift_d = 1'b0;
          if (item_i.op == sli_pkg::OP_INSERT) begin
            if (is_full) begin
              finish = 1'b1;
              status = sli_pkg::ST_FULL;
            end else if (is_empty) begin
              we      = 1'b1;
              waddr   = '0;
              wdata   = item_i.value;
              count_d = CW'(1);
              finish  = 1'b1;
            end else begin
              k_d = AW'(count_q - CW'(1));
            end
          end else begin
            if (is_empty) begin
              finish = 1'b1;
              status = sli_pkg::ST_NOT_FOUND;
            end else begin
              k_d = '0;
            end
          end
        end
      end
      sli_pkg::B_READ: begin
      end
      sli_pkg::B_EVAL: begin
        if (op_q == sli_pkg::OP_INSERT) begin
          // Walk down from the top: larger or equal entries move up one slot.
          we    = 1'b1;
          waddr = k_q + 1'b1;
          if (rd_ge) begin
            wdata = rdata;
            if (!k_zero) begin
              k_d = k_q - 1'b1;
            end
          end else begin
            wdata   = val_q;
            count_d = count_q + CW'(1);
            finish  = 1'b1;
          end
        end else if (!shift_q) begin
          // Search for the first equal entry.
          if (rd_eq) begin
            if (is_last) begin
              count_d = count_q - CW'(1);
              finish  = 1'b1;
            end else begin
              shift_d = 1'b1;
              k_d     = k_q + 1'b1;
            end
          end else if (is_last) begin
            finish = 1'b1;
            status = sli_pkg::ST_NOT_FOUND;
          end else begin
            k_d = k_q + 1'b1;
          end
        end else begin
          // Close the gap: each later entry moves down one slot.
          we    = 1'b1;
          waddr = k_q - 1'b1;
          wdata = rdata;
          if (is_last) begin
            count_d = count_q - CW'(1);
            finish  = 1'b1;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      sli_pkg::B_WRV: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = val_q;
        count_d = count_q + CW'(1);
        finish  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The smallest entry is mirrored in a register whenever slot zero is written.
  always_comb begin
    head_d = head_q;
    if (we && (waddr == '0)) begin
      head_d = wdata;
    end
    res_d.status      = status;
    res_d.entry_count = sli_pkg::COUNT_OUT_W'(count_d);
    res_d.head_valid  = (count_d != '0);
    res_d.head_value  = (count_d != '0) ? head_d : '0;
  end

  assign ram_we_o    = we;
  assign ram_waddr_o = waddr;
  assign ram_wdata_o = wdata;
  assign ram_raddr_o = k_q;
  assign done_o      = done_q;
  assign result_o    = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sli_pkg::B_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= finish;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    op_q    <= op_d;
    val_q   <= val_d;
    shift_q <= shift_d;
    head_q  <= head_d;
    if (finish) begin
      res_q <= res_d;
    end
  end

endmodule

### sv/sli_checker.sv
// Port-level checks for the sorted list insert and delete unit, bound to
// its top level. Depends on sli_pkg and the unit's assertion macro header.
`include "sorted_list_insert_delete_unit_defines.svh"

module sli_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_i,
  input logic             done_i,
  input sli_pkg::result_t result_i
);

  logic accepted;
  logic res_empty;
  logic res_full;

  assign accepted  = start_i && !busy_i;
  assign res_empty = done_i && !result_i.head_valid;
  assign res_full  = done_i && (result_i.status == sli_pkg::ST_FULL);

  // An empty list reports a zero head value.
  `SLI_ASSERT_IMPLY(a_empty_head_zero, clk_i, rst_ni, res_empty, result_i.head_value == '0)

  // A refused insert can only happen with entries held.
  `SLI_ASSERT_IMPLY(a_full_has_head, clk_i, rst_ni, res_full, result_i.head_valid)

  // No result can appear in the cycle right after reset.
  `SLI_ASSERT_NEXT_NORST(a_no_result_after_reset, clk_i, !rst_ni, !done_i)

  // A command taken at the first edge after reset sees no result beside it.
  `SLI_ASSERT_IMPLY(a_no_instant_result, clk_i, rst_ni, $past(!rst_ni) && accepted, !done_i)

endmodule

bind sorted_list_insert_delete_unit sli_checker u_sli_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start),
  .busy_i   (busy),
  .done_i   (done_o),
  .result_i (result_o)
);
